[src/sles_pkg.sv]
// Shared constants, codes and types for the status LED effect sequencer.
package sles_pkg;

    // item kinds
    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_SET  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    // LED modes
    localparam logic [2:0] MODE_IDLE     = 3'd0;
    localparam logic [2:0] MODE_WARNING  = 3'd2;
    localparam logic [2:0] MODE_CHARGING = 3'd3;
    localparam logic [2:0] MODE_FULL     = 3'd4;
    localparam logic [2:0] MODE_FAULT    = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_IDLE_COLOR     = 3'd0;
    localparam logic [2:0] CFG_WARN_COLOR     = 3'd1;
    localparam logic [2:0] CFG_BREATH_MIN     = 3'd2;
    localparam logic [2:0] CFG_BREATH_MAX     = 3'd3;
    localparam logic [2:0] CFG_FLASH_INTERVAL = 3'd4;
    localparam logic [2:0] CFG_BLINK_INTERVAL = 3'd5;
    localparam logic [2:0] CFG_BREATH_STEP    = 3'd6;

    localparam logic [23:0] RST_IDLE_COLOR     = 24'h222222;
    localparam logic [23:0] RST_WARN_COLOR     = 24'h808000;
    localparam logic [7:0]  RST_BREATH_MIN     = 8'd4;
    localparam logic [7:0]  RST_BREATH_MAX     = 8'd50;
    localparam logic [15:0] RST_FLASH_INTERVAL = 16'd500;
    localparam logic [15:0] RST_BLINK_INTERVAL = 16'd250;
    localparam logic [15:0] RST_BREATH_STEP    = 16'd40;

    localparam logic [2:0] FLASH_STEPS = 3'd6;

    // breathing period = odd factor << shift (6000 ms)
    localparam int BREATH_SHIFT  = 4;
    localparam int BREATH_ODD    = 375;
    localparam int BREATH_PERIOD = BREATH_ODD << BREATH_SHIFT;
    localparam int BREATH_HALF   = BREATH_PERIOD / 2;

    // reciprocals of the odd factor; estimate for the modulo, exact for the level
    localparam int ELAPSED_SHIFT = 36;
    localparam logic [27:0] ELAPSED_RECIP =
        28'((64'd1 << ELAPSED_SHIFT) / 64'(BREATH_ODD));
    localparam int LEVEL_SHIFT = 26;
    localparam logic [17:0] LEVEL_RECIP =
        18'(((64'd1 << LEVEL_SHIFT) + 64'(BREATH_ODD) - 64'd1) / 64'(BREATH_ODD));

    typedef struct packed {
        logic [23:0] idle_color;
        logic [23:0] warn_color;
        logic [7:0]  breath_min;
        logic [7:0]  breath_max;
        logic [15:0] flash_interval;
        logic [15:0] blink_interval;
        logic [15:0] breath_step;
    } cfg_t;

    // per-item result carried down the level pipeline
    typedef struct packed {
        logic        sent;
        logic        breath;  // color comes from the breathing level
        logic [23:0] color;
        logic        busy;
    } side_t;

endpackage

[src/status_led_effect_sequencer_top.sv]
// Top level of the status LED effect sequencer.
//
// Input channel (in_valid/in_ready): one item per transfer carrying kind
// (tick, set mode, transfer done), led_state, blink_request and now_ms.
// Output channel (out_valid/out_ready): exactly one result per input item,
// in order: frame_sent, color (zero unless a frame started) and
// transfer_busy. Configuration: cfg_we with cfg_index and cfg_data writes
// one register per cycle; index 7 is ignored.
// Throughput is one item per cycle while the receiver does not stall. From
// input transfer to output valid, the transfer loads the input register,
// then the state update and the stages of the breathing level path (elapsed
// split, reciprocal multiply for the period modulo, raw remainder, remainder
// fixup and triangle, span multiply, divide by half period, saturation).
// Every item takes the same path so order is preserved.
// When the receiver stalls, the whole pipeline holds and in_ready drops in
// the same cycle. Reset loads default colors and intervals, idle mode, an
// update pending and a ready link; the pipeline comes up empty.
module status_led_effect_sequencer_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic [2:0]  led_state,
    input  logic        blink_request,
    input  logic [31:0] now_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        frame_sent,
    output logic [23:0] color,
    output logic        transfer_busy,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    sles_pkg::cfg_t  cfg_reg;
    sles_pkg::side_t ctrl_side;
    sles_pkg::side_t res_side;

    logic        advance;
    logic        in_vld_reg;
    logic [1:0]  kind_reg;
    logic [2:0]  led_state_reg;
    logic        blink_request_reg;
    logic [31:0] now_ms_reg;
    logic [31:0] breath_elapsed;

    assign advance  = !out_valid || out_ready;
    assign in_ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.idle_color     <= sles_pkg::RST_IDLE_COLOR;
            cfg_reg.warn_color     <= sles_pkg::RST_WARN_COLOR;
            cfg_reg.breath_min     <= sles_pkg::RST_BREATH_MIN;
            cfg_reg.breath_max     <= sles_pkg::RST_BREATH_MAX;
            cfg_reg.flash_interval <= sles_pkg::RST_FLASH_INTERVAL;
            cfg_reg.blink_interval <= sles_pkg::RST_BLINK_INTERVAL;
            cfg_reg.breath_step    <= sles_pkg::RST_BREATH_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sles_pkg::CFG_IDLE_COLOR:     cfg_reg.idle_color     <= cfg_data;
                sles_pkg::CFG_WARN_COLOR:     cfg_reg.warn_color     <= cfg_data;
                sles_pkg::CFG_BREATH_MIN:     cfg_reg.breath_min     <= cfg_data[7:0];
                sles_pkg::CFG_BREATH_MAX:     cfg_reg.breath_max     <= cfg_data[7:0];
                sles_pkg::CFG_FLASH_INTERVAL: cfg_reg.flash_interval <= cfg_data[15:0];
                sles_pkg::CFG_BLINK_INTERVAL: cfg_reg.blink_interval <= cfg_data[15:0];
                sles_pkg::CFG_BREATH_STEP:    cfg_reg.breath_step    <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (advance)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg          <= kind;
            led_state_reg     <= led_state;
            blink_request_reg <= blink_request;
            now_ms_reg        <= now_ms;
        end
    end

    sles_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (in_vld_reg && advance),
        .kind           (kind_reg),
        .led_state      (led_state_reg),
        .blink_request  (blink_request_reg),
        .now_ms         (now_ms_reg),
        .cfg            (cfg_reg),
        .side           (ctrl_side),
        .breath_elapsed (breath_elapsed)
    );

    sles_level u_level (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .in_vld     (in_vld_reg),
        .in_side    (ctrl_side),
        .elapsed    (breath_elapsed),
        .breath_min (cfg_reg.breath_min),
        .breath_max (cfg_reg.breath_max),
        .out_vld    (out_valid),
        .out_side   (res_side)
    );

    assign frame_sent    = res_side.sent;
    assign color         = res_side.color;
    assign transfer_busy = res_side.busy;

endmodule

[src/sles_ctrl.sv]
// Mode, timer, flash and link state; decides per item whether a frame starts.
module sles_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic [1:0]          kind,
    input  logic [2:0]          led_state,
    input  logic                blink_request,
    input  logic [31:0]         now_ms,
    input  sles_pkg::cfg_t      cfg,
    output sles_pkg::side_t     side,
    output logic [31:0]         breath_elapsed
);

    logic [2:0]  mode_reg, mode_next;
    logic        blink_on_reg, blink_on_next;
    logic [31:0] last_update_reg, last_update_next;
    logic [31:0] breath_start_reg, breath_start_next;
    logic        phase_reg, phase_next;
    logic        update_pending_reg, update_pending_next;
    logic        flash_active_reg, flash_active_next;
    logic [2:0]  flash_count_reg, flash_count_next;
    logic        link_ready_reg, link_ready_next;

    logic [31:0] since_last;
    logic [2:0]  flash_step;
    logic        changed;
    logic        send_req;
    logic        clear_pending;
    logic        breath;
    logic        sent;
    logic [23:0] send_color;

    assign since_last     = now_ms - last_update_reg;
    assign flash_step     = flash_count_reg + 3'd1;
    assign changed        = (led_state != mode_reg) || (blink_request != blink_on_reg);
    assign breath_elapsed = now_ms - breath_start_reg;

    always_comb
    begin
        mode_next           = mode_reg;
        blink_on_next       = blink_on_reg;
        last_update_next    = last_update_reg;
        breath_start_next   = breath_start_reg;
        phase_next          = phase_reg;
        update_pending_next = update_pending_reg;
        flash_active_next   = flash_active_reg;
        flash_count_next    = flash_count_reg;
        link_ready_next     = link_ready_reg;
        send_req            = 1'b0;
        clear_pending       = 1'b0;
        breath              = 1'b0;
        sent                = 1'b0;
        send_color          = 24'd0;

        case (kind)
            sles_pkg::KIND_TICK:
            begin
                if (flash_active_reg)
                begin
                    if (since_last >= {16'd0, cfg.flash_interval})
                    begin
                        last_update_next = now_ms;
                        flash_count_next = flash_step;
                        send_req         = 1'b1;
                        if (flash_step >= sles_pkg::FLASH_STEPS)
                        begin
                            flash_active_next = 1'b0;
                            send_color        = cfg.idle_color;
                        end
                        else
                        begin
                            send_color = phase_reg ? cfg.warn_color : 24'd0;
                            phase_next = !phase_reg;
                        end
                    end
                end
                else if (mode_reg == sles_pkg::MODE_CHARGING)
                begin
                    if (since_last >= {16'd0, cfg.breath_step})
                    begin
                        last_update_next = now_ms;
                        send_req         = 1'b1;
                        breath           = 1'b1;
                    end
                end
                else
                begin
                    if (mode_reg == sles_pkg::MODE_WARNING && blink_on_reg)
                    begin
                        if (since_last >= {16'd0, cfg.blink_interval})
                        begin
                            last_update_next = now_ms;
                            phase_next       = !phase_reg;
                            send_req         = 1'b1;
                            clear_pending    = 1'b1;
                        end
                    end
                    else if (update_pending_reg)
                    begin
                        send_req      = 1'b1;
                        clear_pending = 1'b1;
                    end
                    if (mode_reg == sles_pkg::MODE_WARNING)
                        send_color = (blink_on_reg && !phase_next) ? 24'd0 : cfg.warn_color;
                    else
                        send_color = cfg.idle_color;
                end
                // a busy link keeps timers moving but starts no frame
                if (send_req && link_ready_reg)
                begin
                    link_ready_next = 1'b0;
                    sent            = 1'b1;
                    if (clear_pending)
                        update_pending_next = 1'b0;
                end
            end
            sles_pkg::KIND_SET:
            begin
                if (led_state == sles_pkg::MODE_CHARGING || led_state == sles_pkg::MODE_FULL)
                    flash_active_next = 1'b0;
                else if (led_state == sles_pkg::MODE_FAULT &&
                         mode_reg != sles_pkg::MODE_FAULT && !flash_active_reg)
                begin
                    flash_active_next = 1'b1;
                    flash_count_next  = 3'd0;
                    phase_next        = 1'b1;
                    last_update_next  = now_ms - {16'd0, cfg.flash_interval};
                end
                mode_next     = led_state;
                blink_on_next = blink_request;
                if (changed)
                begin
                    update_pending_next = 1'b1;
                    last_update_next    = now_ms - {16'd0, cfg.breath_step};
                    if (led_state == sles_pkg::MODE_CHARGING)
                        breath_start_next = now_ms;
                end
            end
            sles_pkg::KIND_DONE:
            begin
                link_ready_next = 1'b1;
            end
            default:
            begin
            end
        endcase

        side.sent   = sent;
        side.breath = sent && breath;
        side.color  = (sent && !breath) ? send_color : 24'd0;
        side.busy   = !link_ready_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= sles_pkg::MODE_IDLE;
            blink_on_reg       <= 1'b0;
            last_update_reg    <= 32'd0;
            breath_start_reg   <= 32'd0;
            phase_reg          <= 1'b0;
            update_pending_reg <= 1'b1;
            flash_active_reg   <= 1'b0;
            flash_count_reg    <= 3'd0;
            link_ready_reg     <= 1'b1;
        end
        else if (en)
        begin
            mode_reg           <= mode_next;
            blink_on_reg       <= blink_on_next;
            last_update_reg    <= last_update_next;
            breath_start_reg   <= breath_start_next;
            phase_reg          <= phase_next;
            update_pending_reg <= update_pending_next;
            flash_active_reg   <= flash_active_next;
            flash_count_reg    <= flash_count_next;
            link_ready_reg     <= link_ready_next;
        end
    end

endmodule

[src/sles_level.sv]
// Pipeline that turns the breathing elapsed time into a gray level color.
module sles_level (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_vld,
    input  sles_pkg::side_t     in_side,
    input  logic [31:0]         elapsed,
    input  logic [7:0]          breath_min,
    input  logic [7:0]          breath_max,
    output logic                out_vld,
    output sles_pkg::side_t     out_side
);

    logic [6:0] vld_reg;

    sles_pkg::side_t side_a_reg, side_b_reg, side_c_reg, side_d_reg;
    sles_pkg::side_t side_e_reg, side_f_reg, side_g_reg;

    // stage A: elapsed split into high part and low bits
    logic [27:0] dhi_a_reg;
    logic [3:0]  dlo_a_reg, dlo_b_reg, dlo_c_reg;
    // stage B: reciprocal product
    logic [55:0] prod_b_reg;
    logic [9:0]  dhi_b_reg;
    // stage C: remainder before correction
    logic [19:0] q_est;
    logic [9:0]  qm_lo;
    logic [9:0]  rraw_c_reg;
    // stage D: triangle value
    logic [8:0]  rem;
    logic [12:0] phase_ms;
    logic [11:0] tri_next, tri_d_reg;
    // stage E: triangle times span
    logic [7:0]  span;
    logic [19:0] sp_e_reg;
    // stage F: divide by half period
    logic [34:0] lm_f_reg;
    // stage G: output
    logic [8:0]  quo;
    logic [9:0]  level_sum;
    logic [7:0]  level;
    sles_pkg::side_t side_g_next;

    assign q_est    = prod_b_reg[55:36];
    assign qm_lo    = 10'(q_est * 20'(sles_pkg::BREATH_ODD));
    assign rem      = (rraw_c_reg >= 10'(sles_pkg::BREATH_ODD)) ?
                      9'(rraw_c_reg - 10'(sles_pkg::BREATH_ODD)) : rraw_c_reg[8:0];
    assign phase_ms = {rem, dlo_c_reg};
    assign tri_next = (phase_ms < 13'(sles_pkg::BREATH_HALF)) ? phase_ms[11:0] :
                      12'(13'(sles_pkg::BREATH_PERIOD) - phase_ms);
    assign span     = (breath_max >= breath_min) ? (breath_max - breath_min) : 8'd0;
    assign quo      = lm_f_reg[34:26];
    assign level_sum = {2'b00, breath_min} + {1'b0, quo};
    assign level    = (level_sum > 10'd255) ? 8'hFF : level_sum[7:0];

    always_comb
    begin
        side_g_next = side_f_reg;
        if (side_f_reg.breath)
            side_g_next.color = {level, level, level};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[5:0], in_vld};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_a_reg <= in_side;
            dhi_a_reg  <= elapsed[31:4];
            dlo_a_reg  <= elapsed[3:0];

            side_b_reg <= side_a_reg;
            prod_b_reg <= 56'(dhi_a_reg) * 56'(sles_pkg::ELAPSED_RECIP);
            dhi_b_reg  <= dhi_a_reg[9:0];
            dlo_b_reg  <= dlo_a_reg;

            side_c_reg <= side_b_reg;
            rraw_c_reg <= dhi_b_reg - qm_lo;
            dlo_c_reg  <= dlo_b_reg;

            side_d_reg <= side_c_reg;
            tri_d_reg  <= tri_next;

            side_e_reg <= side_d_reg;
            sp_e_reg   <= 20'(tri_d_reg) * 20'(span);

            side_f_reg <= side_e_reg;
            lm_f_reg   <= 35'(sp_e_reg[19:3]) * 35'(sles_pkg::LEVEL_RECIP);

            side_g_reg <= side_g_next;
        end
    end

    assign out_vld  = vld_reg[6];
    assign out_side = side_g_reg;

endmodule

[sim/status_led_effect_sequencer_top_test.sv]
// Self-checking testbench for the status LED effect sequencer: random traffic, scoreboard.
module status_led_effect_sequencer_top_test;
    import sles_pkg::*;

    localparam logic [1:0]  KIND_UNUSED       = 2'd3;
    localparam logic [2:0]  MODE_SPARE6       = 3'd6;
    localparam logic [2:0]  MODE_SPARE7       = 3'd7;
    localparam logic [2:0]  CFG_UNUSED        = 3'd7;
    localparam logic [2:0]  FLASH_HALF_CYCLES = 3'd6;
    localparam logic [31:0] LEVEL_PERIOD_MS   = 32'd6000;
    localparam logic [31:0] LEVEL_HALF_MS     = 32'd3000;
    localparam int          PHASE_ITEMS       = 160;
    localparam int          DRAIN_LIMIT       = 50000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  led_state;
        logic        blink;
        logic [31:0] now;
    } led_item_t;

    typedef struct packed {
        logic        sent;
        logic [23:0] color;
        logic        busy;
    } frame_t;

    typedef struct {
        logic [23:0] idle_color, warn_color;
        logic [7:0]  lvl_min, lvl_max;
        logic [15:0] flash_ms, blink_ms, step_ms;
    } led_settings_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = '0;
    logic [2:0]  led_state = '0;
    logic        blink_request = 1'b0;
    logic [31:0] now_ms = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        frame_sent;
    logic [23:0] color;
    logic        transfer_busy;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;

    status_led_effect_sequencer_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .led_state     (led_state),
        .blink_request (blink_request),
        .now_ms        (now_ms),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_sent    (frame_sent),
        .color         (color),
        .transfer_busy (transfer_busy),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // register mirror and sequencer state
    led_settings_t regs;
    logic [2:0]    st_mode;
    logic          st_blink;
    logic [31:0]   st_last_ms;
    logic [31:0]   st_breath_start;
    logic          st_phase;
    logic          st_pending;
    logic          st_flash;
    logic [2:0]    st_flash_cnt;
    logic          st_link_ready;

    led_item_t items_to_send[$];
    frame_t    frames_due[$];
    int        mismatches = 0;

    // sender and receiver pacing
    int   tx_gap_max = 3;
    int   rx_stall_pct = 30;
    logic rx_hold_req = 1'b0;
    logic rx_hold_done = 1'b0;
    int   gap_left = 0;
    int   burst_left = 1;
    int   hold_left = 0;
    int   run_left = 0;
    logic [31:0] t_ms = '0;

    function automatic frame_t advance_sequencer(input led_item_t it);
        frame_t      r;
        logic [31:0] since, elapsed, tri_ms, span, level;
        logic [23:0] c;
        logic        emit;
        logic [2:0]  prev_mode;
        logic        prev_blink;
        r = '0;
        c = '0;
        emit = 1'b0;
        case (it.kind)
            KIND_TICK: begin
                since = it.now - st_last_ms;
                if (st_flash) begin
                    if (since >= 32'(regs.flash_ms)) begin
                        st_last_ms = it.now;
                        c = st_phase ? regs.warn_color : 24'h0;
                        st_flash_cnt = st_flash_cnt + 3'd1;
                        if (st_flash_cnt >= FLASH_HALF_CYCLES) begin
                            st_flash = 1'b0;
                            c = regs.idle_color;
                        end else begin
                            st_phase = !st_phase;
                        end
                        emit = 1'b1;
                    end
                end else if (st_mode == MODE_CHARGING) begin
                    if (since >= 32'(regs.step_ms)) begin
                        st_last_ms = it.now;
                        elapsed = (it.now - st_breath_start) % LEVEL_PERIOD_MS;
                        tri_ms = (elapsed < LEVEL_HALF_MS) ? elapsed : LEVEL_PERIOD_MS - elapsed;
                        span = (regs.lvl_max >= regs.lvl_min) ?
                               32'(regs.lvl_max) - 32'(regs.lvl_min) : 32'd0;
                        level = 32'(regs.lvl_min) + (tri_ms * span) / LEVEL_HALF_MS;
                        if (level > 32'd255)
                            level = 32'd255;
                        c = {3{level[7:0]}};
                        emit = 1'b1;
                    end
                end else begin
                    if (st_mode == MODE_WARNING && st_blink) begin
                        if (since >= 32'(regs.blink_ms)) begin
                            st_last_ms = it.now;
                            st_phase = !st_phase;
                            emit = 1'b1;
                        end
                    end else begin
                        emit = st_pending;
                    end
                    if (emit) begin
                        if (st_mode == MODE_WARNING)
                            c = (st_blink && !st_phase) ? 24'h0 : regs.warn_color;
                        else
                            c = regs.idle_color;
                        // pending only clears once the frame actually goes out
                        if (st_link_ready)
                            st_pending = 1'b0;
                    end
                end
                if (emit && st_link_ready) begin
                    st_link_ready = 1'b0;
                    r.sent = 1'b1;
                    r.color = c;
                end
            end
            KIND_SET: begin
                prev_mode = st_mode;
                prev_blink = st_blink;
                if (it.led_state == MODE_CHARGING || it.led_state == MODE_FULL) begin
                    st_flash = 1'b0;
                end else if (it.led_state == MODE_FAULT && st_mode != MODE_FAULT
                             && !st_flash) begin
                    st_flash = 1'b1;
                    st_flash_cnt = '0;
                    st_phase = 1'b1;
                    st_last_ms = it.now - 32'(regs.flash_ms);
                end
                st_mode = it.led_state;
                st_blink = it.blink;
                if (it.led_state != prev_mode || it.blink != prev_blink) begin
                    st_pending = 1'b1;
                    st_last_ms = it.now - 32'(regs.step_ms);
                    if (it.led_state == MODE_CHARGING)
                        st_breath_start = it.now;
                end
            end
            KIND_DONE: st_link_ready = 1'b1;
            default: ;
        endcase
        r.busy = !st_link_ready;
        return r;
    endfunction

    function automatic void add_item(input logic [1:0] k, input logic [2:0] m,
                                     input logic b, input logic [31:0] t);
        led_item_t it;
        it.kind = k;
        it.led_state = m;
        it.blink = b;
        it.now = t;
        items_to_send.push_back(it);
    endfunction

    function automatic logic [15:0] any_interval();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 8));
            1: return 16'($urandom_range(9, 120));
            2: return 16'($urandom_range(121, 1200));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic queue_random(input int n);
        led_item_t   it;
        int          r;
        logic [15:0] pace;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            it.led_state = 3'($urandom_range(0, 7));
            it.blink = 1'($urandom_range(0, 1));
            if (r < 5) begin
                it.kind = KIND_SET;
                it.led_state = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
                                                          : 3'($urandom_range(0, 5));
            end else if (r < 27) begin
                it.kind = KIND_DONE;
            end else if (r < 29) begin
                it.kind = KIND_UNUSED;
            end else begin
                it.kind = KIND_TICK;
            end
            case ($urandom_range(0, 2))
                0: pace = regs.flash_ms;
                1: pace = regs.blink_ms;
                default: pace = regs.step_ms;
            endcase
            // step time so the interval boundaries get hit exactly and just off
            r = $urandom_range(0, 99);
            if (r >= 98)
                t_ms = $urandom();
            else if (r >= 85)
                t_ms += $urandom_range(0, 4 * pace);
            else if (r >= 55)
                t_ms += pace + $urandom_range(0, 2) - 1;
            else if (r >= 15)
                t_ms += $urandom_range(0, pace);
            it.now = t_ms;
            items_to_send.push_back(it);
        end
    endtask

    task automatic put_reg(input logic [2:0] idx, input logic [23:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            CFG_IDLE_COLOR:     regs.idle_color = data;
            CFG_WARN_COLOR:     regs.warn_color = data;
            CFG_BREATH_MIN:     regs.lvl_min = data[7:0];
            CFG_BREATH_MAX:     regs.lvl_max = data[7:0];
            CFG_FLASH_INTERVAL: regs.flash_ms = data[15:0];
            CFG_BLINK_INTERVAL: regs.blink_ms = data[15:0];
            CFG_BREATH_STEP:    regs.step_ms = data[15:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(input led_settings_t s);
        put_reg(CFG_IDLE_COLOR, s.idle_color);
        put_reg(CFG_WARN_COLOR, s.warn_color);
        put_reg(CFG_BREATH_MIN, {16'h0, s.lvl_min});
        put_reg(CFG_BREATH_MAX, {16'h0, s.lvl_max});
        put_reg(CFG_FLASH_INTERVAL, {8'h0, s.flash_ms});
        put_reg(CFG_BLINK_INTERVAL, {8'h0, s.blink_ms});
        put_reg(CFG_BREATH_STEP, {8'h0, s.step_ms});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait until everything sent has come back, then let the pipeline settle
    task automatic drain();
        int cycles;
        cycles = 0;
        while ((items_to_send.size() != 0 || in_valid || frames_due.size() != 0)
               && cycles < DRAIN_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        if (frames_due.size() != 0 || items_to_send.size() != 0) begin
            $display("%0t: %0d results never arrived, %0d items never taken", $time,
                     frames_due.size(), items_to_send.size());
            mismatches++;
            frames_due.delete();
        end
        repeat (12) @(posedge clk);
    endtask

    // driver
    always @(posedge clk) begin : drive
        led_item_t it;
        logic      take;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            take = 1'b0;
            if (in_valid && in_ready) begin
                it.kind = kind;
                it.led_state = led_state;
                it.blink = blink_request;
                it.now = now_ms;
                frames_due.push_back(advance_sequencer(it));
            end
            if (!in_valid || in_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (items_to_send.size() != 0) begin
                    it = items_to_send.pop_front();
                    take = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 16);
                        gap_left = (tx_gap_max == 0) ? 0 : $urandom_range(1, tx_gap_max);
                    end
                end
                if (take) begin
                    in_valid <= 1'b1;
                    kind <= it.kind;
                    led_state <= it.led_state;
                    blink_request <= it.blink;
                    now_ms <= it.now;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stalls
    always @(posedge clk) begin : watch
        frame_t want;
        logic   rdy;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: result with nothing expected: sent %0b color %06h busy %0b",
                             $time, frame_sent, color, transfer_busy);
                    mismatches++;
                end else begin
                    want = frames_due.pop_front();
                    if (frame_sent !== want.sent) begin
                        $display("%0t: frame_sent expected %0b got %0b", $time,
                                 want.sent, frame_sent);
                        mismatches++;
                    end
                    if (color !== want.color) begin
                        $display("%0t: color expected %06h got %06h", $time,
                                 want.color, color);
                        mismatches++;
                    end
                    if (transfer_busy !== want.busy) begin
                        $display("%0t: transfer_busy expected %0b got %0b", $time,
                                 want.busy, transfer_busy);
                        mismatches++;
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (rx_hold_req && !rx_hold_done) begin
                // long hold-off so the block backs up and stalls its input
                rx_hold_done = 1'b1;
                hold_left = 300;
                rdy = 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                rdy = out_ready;
            end else begin
                rdy = ($urandom_range(0, 99) >= rx_stall_pct);
                run_left = $urandom_range(0, 6);
            end
            out_ready <= rdy;
        end
    end

    initial begin
        led_settings_t s;
        regs.idle_color = 24'h222222;
        regs.warn_color = 24'h808000;
        regs.lvl_min = 8'd4;
        regs.lvl_max = 8'd50;
        regs.flash_ms = 16'd500;
        regs.blink_ms = 16'd250;
        regs.step_ms = 16'd40;
        st_mode = MODE_IDLE;
        st_blink = 1'b0;
        st_last_ms = '0;
        st_breath_start = '0;
        st_phase = 1'b0;
        st_pending = 1'b1;
        st_flash = 1'b0;
        st_flash_cnt = '0;
        st_link_ready = 1'b1;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings
        add_item(KIND_TICK, MODE_IDLE, 1'b0, 32'd0);
        add_item(KIND_TICK, MODE_SPARE7, 1'b1, 32'd1);        // link still busy
        add_item(KIND_DONE, MODE_IDLE, 1'b0, 32'd2);
        add_item(KIND_SET, MODE_WARNING, 1'b1, 32'd100);
        add_item(KIND_TICK, MODE_IDLE, 1'b0, 32'd310);
        add_item(KIND_DONE, MODE_IDLE, 1'b0, 32'd311);
        add_item(KIND_TICK, MODE_IDLE, 1'b0, 32'd560);
        add_item(KIND_SET, MODE_CHARGING, 1'b0, 32'hFFFF_FF00);
        add_item(KIND_DONE, MODE_IDLE, 1'b0, 32'hFFFF_FF01);
        add_item(KIND_TICK, MODE_IDLE, 1'b0, 32'hFFFF_FF00 + LEVEL_HALF_MS); // wraps
        add_item(KIND_DONE, MODE_IDLE, 1'b0, 32'd3000);
        add_item(KIND_SET, MODE_FAULT, 1'b0, 32'd5000);
        for (int k = 1; k <= 6; k++) begin
            add_item(KIND_TICK, MODE_IDLE, 1'b0, 32'd5000 + 32'(500 * k));
            add_item(KIND_DONE, MODE_IDLE, 1'b0, 32'd5001 + 32'(500 * k));
        end
        add_item(KIND_SET, MODE_SPARE7, 1'b1, 32'd9000);
        add_item(KIND_TICK, MODE_IDLE, 1'b0, 32'd9000);
        add_item(KIND_UNUSED, MODE_SPARE6, 1'b1, 32'hFFFF_FFFF);
        add_item(KIND_SET, MODE_FULL, 1'b0, 32'hFFFF_FFFF);
        add_item(KIND_TICK, MODE_IDLE, 1'b0, 32'hFFFF_FFFF);  // pending but link busy
        t_ms = 32'hFFFF_FFFF;
        drain();

        for (int ph = 1; ph <= 10; ph++) begin
            s.idle_color = 24'($urandom());
            s.warn_color = 24'($urandom());
            s.lvl_min = 8'($urandom_range(0, 120));
            s.lvl_max = 8'($urandom_range(120, 255));
            s.flash_ms = any_interval();
            s.blink_ms = any_interval();
            s.step_ms = any_interval();
            case (ph)
                1: begin
                    s.idle_color = 24'hFFFFFF;
                    s.warn_color = 24'hFFFFFF;
                    s.lvl_min = 8'hFF;
                    s.lvl_max = 8'hFF;
                    s.flash_ms = 16'hFFFF;
                    s.blink_ms = 16'hFFFF;
                    s.step_ms = 16'hFFFF;
                end
                2: begin
                    s.idle_color = '0;
                    s.warn_color = '0;
                    s.lvl_min = '0;
                    s.lvl_max = '0;
                    s.flash_ms = '0;
                    s.blink_ms = '0;
                    s.step_ms = '0;
                end
                3: begin
                    // inverted bounds: span counts as zero
                    s.lvl_min = 8'($urandom_range(129, 255));
                    s.lvl_max = 8'($urandom_range(0, 128));
                end
                4: begin
                    s.lvl_min = '0;
                    s.lvl_max = 8'hFF;
                    s.flash_ms = 16'd1;
                    s.blink_ms = 16'd1;
                    s.step_ms = 16'd1;
                end
                default: ;
            endcase
            program_regs(s);
            if (ph == 5) begin
                put_reg(CFG_UNUSED, 24'($urandom()));
                @(posedge clk);
                cfg_we <= 1'b0;
            end
            if (ph == 4) begin
                tx_gap_max <= 0;
                rx_stall_pct <= 0;
                rx_hold_req <= 1'b1;
            end else if (ph == 7) begin
                tx_gap_max <= 0;
                rx_stall_pct <= 0;
            end else begin
                tx_gap_max <= $urandom_range(1, 10);
                rx_stall_pct <= $urandom_range(10, 60);
            end
            queue_random(PHASE_ITEMS);
            drain();
        end

        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #4000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
